>>> rtl/tcw_pkg.sv
// Shared constants, codes and the result descriptor for the text console char writer.
package tcw_pkg;

  // Default geometry
  localparam int TCW_COLUMNS   = 80;
  localparam int TCW_ROW_COUNT = 25;
  localparam int TCW_TAB_WIDTH = 8;

  // Fixed field widths
  localparam int ACTION_W = 2;
  localparam int BYTE_W   = 8;
  localparam int IN_ADDR_W = 11;
  localparam int POS_W    = 11;
  localparam int CELL_W   = 16;
  localparam int CNT_W    = 4;

  // Actions
  localparam logic [ACTION_W-1:0] ACT_PUT   = 2'd0;
  localparam logic [ACTION_W-1:0] ACT_READ  = 2'd1;
  localparam logic [ACTION_W-1:0] ACT_CLEAR = 2'd2;

  // Character codes
  localparam logic [BYTE_W-1:0] CH_TAB   = 8'h09;
  localparam logic [BYTE_W-1:0] CH_LF    = 8'h0a;
  localparam logic [BYTE_W-1:0] CH_CR    = 8'h0d;
  localparam logic [BYTE_W-1:0] CH_SPACE = 8'h20;
  localparam logic [BYTE_W-1:0] CH_DEL   = 8'h7f;

  // Blank cell: grey on black space
  localparam logic [CELL_W-1:0] BLANK_CELL = 16'h0720;

  // One finished item, handed from the engine to the result stage
  typedef struct packed {
    logic              serial;
    logic [BYTE_W-1:0] byte0;
    logic [BYTE_W-1:0] rest;
    logic [CNT_W-1:0]  cnt;
    logic [POS_W-1:0]  pos;
    logic [CELL_W-1:0] cell_word;
  } desc_t;

endpackage

>>> rtl/tcw_engine.sv
// Cell store, cursor and the sequencer that reads, modifies and writes the store.
module tcw_engine
  import tcw_pkg::*;
#(
  parameter int COLUMNS   = TCW_COLUMNS,
  parameter int ROW_COUNT = TCW_ROW_COUNT,
  parameter int TAB_WIDTH = TCW_TAB_WIDTH
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 mirror,
  input  logic                 item_valid,
  output logic                 item_ready,
  input  logic [ACTION_W-1:0]  action,
  input  logic [BYTE_W-1:0]    char_code,
  input  logic [BYTE_W-1:0]    attribute,
  input  logic [IN_ADDR_W-1:0] cell_address,
  input  logic                 emit_free,
  output logic                 desc_load,
  output desc_t                desc
);

  localparam int CELLS = COLUMNS * ROW_COUNT;
  localparam int AW    = $clog2(CELLS);
  localparam int COL_W = $clog2(COLUMNS + 1);
  localparam int ROW_W = $clog2(ROW_COUNT);
  localparam int PH_W  = $clog2(TAB_WIDTH + 1);
  localparam int SW    = COL_W + 1;

  localparam logic [AW-1:0]    COLS_A         = AW'(COLUMNS);
  localparam logic [AW-1:0]    COLS_M1        = AW'(COLUMNS - 1);
  localparam logic [AW-1:0]    ADDR_LAST      = AW'(CELLS - 1);
  localparam logic [AW-1:0]    SCROLL_LAST    = AW'(CELLS - COLUMNS - 1);
  localparam logic [AW-1:0]    LAST_ROW_START = AW'(CELLS - COLUMNS);
  localparam logic [COL_W-1:0] COLS_C         = COL_W'(COLUMNS);
  localparam logic [ROW_W-1:0] ROW_LAST       = ROW_W'(ROW_COUNT - 1);
  localparam logic [CNT_W-1:0] TAB_C          = CNT_W'(TAB_WIDTH);
  localparam logic [PH_W-1:0]  PH_LAST        = PH_W'(TAB_WIDTH - 1);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_READ   = 3'd1;
  localparam logic [2:0] S_FILL   = 3'd2;
  localparam logic [2:0] S_SETTLE = 3'd3;
  localparam logic [2:0] S_SCR_RD = 3'd4;
  localparam logic [2:0] S_SCR_WR = 3'd5;
  localparam logic [2:0] S_DONE   = 3'd6;

  localparam logic [1:0] POST_IDLE   = 2'd0;
  localparam logic [1:0] POST_SETTLE = 2'd1;
  localparam logic [1:0] POST_DONE   = 2'd2;

  logic [2:0]        state, state_next;
  logic [COL_W-1:0]  col, col_next;
  logic [ROW_W-1:0]  row, row_next;
  logic [PH_W-1:0]   phase, phase_next;
  logic [AW-1:0]     fill_addr, fill_addr_next;
  logic [AW-1:0]     fill_end, fill_end_next;
  logic [1:0]        fill_post, fill_post_next;
  logic [AW-1:0]     scan, scan_next;
  logic [CELL_W-1:0] cell_word, cell_word_next;
  logic              d_serial, d_serial_next;
  logic [BYTE_W-1:0] d_byte0, d_byte0_next;
  logic [BYTE_W-1:0] d_rest, d_rest_next;
  logic [CNT_W-1:0]  d_cnt, d_cnt_next;

  // Cell store
  logic [CELL_W-1:0] mem [CELLS];
  logic              wr_en, rd_en;
  logic [AW-1:0]     wr_addr, rd_addr;
  logic [CELL_W-1:0] wr_data, rd_data;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

  // Cursor arithmetic
  logic [AW-1:0]     base, cur_addr, row_end;
  logic [CNT_W-1:0]  tab_t;
  logic [SW-1:0]     tab_sum;
  logic              tab_over;
  logic [COL_W-1:0]  col_inc, col_dec;
  logic              at_last_row, accept, in_range;
  logic [BYTE_W-1:0] e_byte0, e_rest;
  logic [CNT_W-1:0]  e_cnt;

  assign base        = AW'(row) * COLS_A;
  assign cur_addr    = base + AW'(col);
  assign row_end     = base + COLS_M1;
  assign tab_t       = TAB_C - CNT_W'(phase);
  assign tab_sum     = SW'(col) + SW'(tab_t);
  assign tab_over    = tab_sum > SW'(COLUMNS);
  assign col_inc     = col + COL_W'(1);
  assign col_dec     = (col != '0) ? col - COL_W'(1) : col;
  assign at_last_row = (row == ROW_LAST);
  assign item_ready  = (state == S_IDLE);
  assign accept      = item_valid && item_ready;
  assign in_range    = int'(cell_address) < CELLS;

  // Echo bytes for a printed character
  always_comb begin
    e_byte0 = char_code;
    e_rest  = '0;
    e_cnt   = CNT_W'(1);
    case (char_code)
      CH_LF: begin
        e_byte0 = CH_CR;
        e_rest  = CH_LF;
        e_cnt   = CNT_W'(2);
      end
      CH_TAB: begin
        e_byte0 = CH_SPACE;
        e_rest  = CH_SPACE;
        e_cnt   = tab_t;
      end
      CH_CR:   e_byte0 = CH_CR;
      CH_DEL:  e_byte0 = CH_SPACE;
      default: e_byte0 = char_code;
    endcase
  end

  always_comb begin
    state_next     = state;
    col_next       = col;
    row_next       = row;
    phase_next     = phase;
    fill_addr_next = fill_addr;
    fill_end_next  = fill_end;
    fill_post_next = fill_post;
    scan_next      = scan;
    cell_word_next = cell_word;
    d_serial_next  = d_serial;
    d_byte0_next   = d_byte0;
    d_rest_next    = d_rest;
    d_cnt_next     = d_cnt;
    wr_en          = 1'b0;
    wr_addr        = cur_addr;
    wr_data        = BLANK_CELL;
    rd_en          = 1'b0;
    rd_addr        = scan + COLS_A;
    desc_load      = 1'b0;

    case (state)
      S_IDLE: begin
        if (accept) begin
          cell_word_next = '0;
          d_serial_next  = mirror && (action == ACT_PUT);
          d_byte0_next   = '0;
          d_rest_next    = '0;
          d_cnt_next     = CNT_W'(1);
          if (mirror && (action == ACT_PUT)) begin
            d_byte0_next = e_byte0;
            d_rest_next  = e_rest;
            d_cnt_next   = e_cnt;
          end
          state_next = S_DONE;
          case (action)
            ACT_PUT: begin
              case (char_code)
                CH_LF: begin
                  fill_addr_next = cur_addr;
                  fill_end_next  = row_end;
                  fill_post_next = POST_SETTLE;
                  col_next       = COLS_C;
                  state_next     = S_FILL;
                end
                CH_TAB: begin
                  fill_addr_next = cur_addr;
                  fill_end_next  = tab_over ? row_end : cur_addr + AW'(tab_t) - AW'(1);
                  fill_post_next = POST_SETTLE;
                  col_next       = tab_over ? COLS_C : COL_W'(tab_sum);
                  phase_next     = '0;
                  state_next     = S_FILL;
                end
                CH_CR: begin
                  col_next   = '0;
                  phase_next = '0;
                end
                CH_DEL: begin
                  wr_en    = 1'b1;
                  wr_addr  = base + AW'(col_dec);
                  wr_data  = {attribute, CH_SPACE};
                  col_next = col_dec;
                  if (col != '0) begin
                    phase_next = (phase == '0) ? PH_LAST : phase - PH_W'(1);
                  end
                end
                default: begin
                  wr_en   = 1'b1;
                  wr_data = {attribute, char_code};
                  if (col_inc == COLS_C) begin
                    col_next   = '0;
                    phase_next = '0;
                    if (at_last_row) begin
                      scan_next  = '0;
                      state_next = S_SCR_RD;
                    end else begin
                      row_next = row + ROW_W'(1);
                    end
                  end else begin
                    col_next   = col_inc;
                    phase_next = (phase == PH_LAST) ? '0 : phase + PH_W'(1);
                  end
                end
              endcase
            end
            ACT_READ: begin
              if (in_range) begin
                rd_en      = 1'b1;
                rd_addr    = AW'(cell_address);
                state_next = S_READ;
              end
            end
            ACT_CLEAR: begin
              col_next       = '0;
              row_next       = '0;
              phase_next     = '0;
              fill_addr_next = '0;
              fill_end_next  = ADDR_LAST;
              fill_post_next = POST_DONE;
              state_next     = S_FILL;
            end
            default: state_next = S_DONE;
          endcase
        end
      end
      S_READ: begin
        cell_word_next = rd_data;
        state_next     = S_DONE;
      end
      S_FILL: begin
        wr_en   = 1'b1;
        wr_addr = fill_addr;
        if (fill_addr == fill_end) begin
          case (fill_post)
            POST_IDLE:   state_next = S_IDLE;
            POST_SETTLE: state_next = S_SETTLE;
            default:     state_next = S_DONE;
          endcase
        end else begin
          fill_addr_next = fill_addr + AW'(1);
        end
      end
      S_SETTLE: begin
        state_next = S_DONE;
        if (col >= COLS_C) begin
          col_next   = '0;
          phase_next = '0;
          if (at_last_row) begin
            scan_next  = '0;
            state_next = S_SCR_RD;
          end else begin
            row_next = row + ROW_W'(1);
          end
        end
      end
      S_SCR_RD: begin
        rd_en      = 1'b1;
        state_next = S_SCR_WR;
      end
      S_SCR_WR: begin
        wr_en   = 1'b1;
        wr_addr = scan;
        wr_data = rd_data;
        if (scan == SCROLL_LAST) begin
          fill_addr_next = LAST_ROW_START;
          fill_end_next  = ADDR_LAST;
          fill_post_next = POST_DONE;
          state_next     = S_FILL;
        end else begin
          scan_next  = scan + AW'(1);
          state_next = S_SCR_RD;
        end
      end
      S_DONE: begin
        if (emit_free) begin
          desc_load  = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_FILL;
      col       <= '0;
      row       <= '0;
      phase     <= '0;
      fill_addr <= '0;
      fill_end  <= ADDR_LAST;
      fill_post <= POST_IDLE;
      scan      <= '0;
    end else begin
      state     <= state_next;
      col       <= col_next;
      row       <= row_next;
      phase     <= phase_next;
      fill_addr <= fill_addr_next;
      fill_end  <= fill_end_next;
      fill_post <= fill_post_next;
      scan      <= scan_next;
    end
  end

  always_ff @(posedge clk) begin
    cell_word <= cell_word_next;
    d_serial  <= d_serial_next;
    d_byte0   <= d_byte0_next;
    d_rest    <= d_rest_next;
    d_cnt     <= d_cnt_next;
  end

  assign desc.serial    = d_serial;
  assign desc.byte0     = d_byte0;
  assign desc.rest      = d_rest;
  assign desc.cnt       = d_cnt;
  assign desc.pos       = POS_W'(cur_addr);
  assign desc.cell_word = cell_word;

  a_col_idle: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE) |-> (col < COLS_C))
    else $error("cursor column at line end while idle");

  a_row_range: assert property (@(posedge clk) disable iff (rst)
    row <= ROW_LAST)
    else $error("cursor row past last row");

  a_wr_range: assert property (@(posedge clk) disable iff (rst)
    wr_en |-> (wr_addr <= ADDR_LAST))
    else $error("cell write out of range");

  a_fill_order: assert property (@(posedge clk) disable iff (rst)
    (state == S_FILL) |-> (fill_addr <= fill_end))
    else $error("fill pointer passed its end");

  a_scroll_pair: assert property (@(posedge clk) disable iff (rst)
    (state == S_SCR_WR) |-> ($past(state) == S_SCR_RD))
    else $error("scroll write without its read");

endmodule

>>> rtl/tcw_emitter.sv
// Result output register: expands one finished item into its serial byte transfers.
module tcw_emitter
  import tcw_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              desc_load,
  input  desc_t             desc,
  output logic              emit_free,
  output logic              result_valid,
  input  logic              result_ready,
  output logic              serial_valid,
  output logic [BYTE_W-1:0] serial_byte,
  output logic [POS_W-1:0]  cursor_position,
  output logic [CELL_W-1:0] cell_data,
  output logic              last
);

  logic [CNT_W-1:0]  left;
  logic [BYTE_W-1:0] rest;
  logic              xfer;

  assign xfer      = result_valid && result_ready;
  assign emit_free = !result_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (desc_load) begin
      result_valid <= 1'b1;
    end else if (xfer && (left == '0)) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (desc_load) begin
      serial_valid    <= desc.serial;
      serial_byte     <= desc.byte0;
      rest            <= desc.rest;
      left            <= desc.cnt - CNT_W'(1);
      last            <= (desc.cnt == CNT_W'(1));
      cursor_position <= desc.pos;
      cell_data       <= desc.cell_word;
    end else if (xfer && (left != '0)) begin
      serial_byte <= rest;
      left        <= left - CNT_W'(1);
      last        <= (left == CNT_W'(1));
    end
  end

endmodule

>>> rtl/text_console_char_writer_unit.sv
// Top level of the text console char writer: mirror register, engine and result stage.
//
// Text-mode console engine. The screen is a COLUMNS x ROW_COUNT store of 16-bit words
// (attribute high byte, character low byte) in one single-port-style synchronous RAM,
// plus a cursor. After reset the block runs a clearing pass that writes 0x0720 to every
// cell, one cell per clock, and takes no item until it ends; mirror writes are taken
// throughout. A cell read waits on the registered RAM read, and an out-of-range read
// skips the RAM; newline and tab blank their cells one per clock, and a clear blanks
// every cell. A character, newline or tab that moves the cursor below the last row also
// scrolls: each moved cell is a RAM read followed by a write, and the last row is then
// blanked. The engine makes at most one RAM access per cycle. Results leave through an
// output register, one transfer per clock while result_ready is high; the engine takes
// the next item while earlier results still drain, and stalls only when a new item
// finishes before that register is empty.
// With the mirror register set, a printed character yields one transfer per echoed byte
// (CR LF for newline, one space per skipped column for tab); otherwise every item yields
// a single transfer. last marks the final transfer of an item.
module text_console_char_writer_unit
  import tcw_pkg::*;
#(
  parameter int COLUMNS   = TCW_COLUMNS,
  parameter int ROW_COUNT = TCW_ROW_COUNT,
  parameter int TAB_WIDTH = TCW_TAB_WIDTH
) (
  input  logic                 clk,
  input  logic                 rst,
  // mirror register write
  input  logic                 cfg_write_enable,
  input  logic                 cfg_write_data,
  // input items
  input  logic                 item_valid,
  output logic                 item_ready,
  input  logic [ACTION_W-1:0]  action,
  input  logic [BYTE_W-1:0]    char_code,
  input  logic [BYTE_W-1:0]    attribute,
  input  logic [IN_ADDR_W-1:0] cell_address,
  // results
  output logic                 result_valid,
  input  logic                 result_ready,
  output logic                 serial_valid,
  output logic [BYTE_W-1:0]    serial_byte,
  output logic [POS_W-1:0]     cursor_position,
  output logic [CELL_W-1:0]    cell_data,
  output logic                 last
);

  // Serial mirror enable; the user must write it only while the block is idle, the block itself does not enforce this.
  logic mirror;

  always_ff @(posedge clk) begin
    if (rst) begin
      mirror <= 1'b0;
    end else if (cfg_write_enable) begin
      mirror <= cfg_write_data;
    end
  end

  // Engine to result stage: one descriptor per finished item.
  desc_t desc;
  logic  desc_load;
  logic  emit_free;

  tcw_engine #(
    .COLUMNS   (COLUMNS),
    .ROW_COUNT (ROW_COUNT),
    .TAB_WIDTH (TAB_WIDTH)
  ) u_engine (
    .clk          (clk),
    .rst          (rst),
    .mirror       (mirror),
    .item_valid   (item_valid),
    .item_ready   (item_ready),
    .action       (action),
    .char_code    (char_code),
    .attribute    (attribute),
    .cell_address (cell_address),
    .emit_free    (emit_free),
    .desc_load    (desc_load),
    .desc         (desc)
  );

  // Output register; splits an item into its echo byte transfers.
  tcw_emitter u_emitter (
    .clk             (clk),
    .rst             (rst),
    .desc_load       (desc_load),
    .desc            (desc),
    .emit_free       (emit_free),
    .result_valid    (result_valid),
    .result_ready    (result_ready),
    .serial_valid    (serial_valid),
    .serial_byte     (serial_byte),
    .cursor_position (cursor_position),
    .cell_data       (cell_data),
    .last            (last)
  );

endmodule
